// File: rtl/ar1ps_pkg.sv
// Shared constants, codes and types of the AR(1) penalty score unit.
// Depends on nothing; every other file imports it.
`default_nettype none
package ar1ps_pkg;

  localparam int FRAC_BITS = 16;

  localparam int SAMPLE_W = 32;
  localparam int RHO_W    = 16;
  localparam int SIGMA_W  = 31;
  localparam int MULT_W   = 31;
  localparam int DEV_W    = 34;
  localparam int SUM_W    = 64;
  localparam int SCORE_W  = 48;
  localparam int ERR_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier: A times B, B taken one leg per pass.
  localparam int MUL_LEG   = 18;
  localparam int MUL_A_W   = 36;
  localparam int MUL_NPASS = 4;
  localparam int MUL_B_W   = MUL_LEG * MUL_NPASS;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_K_W   = $clog2(MUL_NPASS);

  // Final division.
  localparam int DSR_W = 2 * SIGMA_W;
  localparam int MS_W  = MULT_W + SUM_W;
  localparam int DVD_W = MS_W + FRAC_BITS - 1;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FEW    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DOMAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RHO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_MODE = 3'd4;

  typedef struct packed {
    logic               start;
    logic [MUL_K_W-1:0] last_pass;
  } mul_req_t;

endpackage
`default_nettype wire

// File: rtl/ar1ps_in_if.sv
// Sample channel: one word is one series sample and its end flag.
// Depends on ar1ps_pkg.
`default_nettype none
interface ar1ps_in_if import ar1ps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/ar1ps_out_if.sv
// Result channel: one word is the score and error code of a series.
// Depends on ar1ps_pkg.
`default_nettype none
interface ar1ps_out_if import ar1ps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, output score, output error_code, input ready);
  modport sink   (input valid, input score, input error_code, output ready);
endinterface
`default_nettype wire

// File: rtl/ar1ps_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on ar1ps_pkg.
`default_nettype none
interface ar1ps_cfg_if import ar1ps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ar1ps_mul.sv
// Shared unsigned multiplier: A times B, one 18-bit leg of B per cycle.
// Depends on ar1ps_pkg.
`default_nettype none
module ar1ps_mul import ar1ps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mul_req_t           req,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_P_W-1:0]      prod
);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_P_W-1:0] acc_r;
  logic [MUL_K_W-1:0] k_r, last_r;
  logic               busy_r, done_r;

  logic [MUL_A_W+MUL_LEG-1:0] pp;
  logic [MUL_P_W-1:0]         pp_sh;

  always_comb begin
    pp    = a_r * b_r[MUL_LEG-1:0];
    pp_sh = MUL_P_W'(pp) << (MUL_LEG * k_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        k_r    <= '0;
        last_r <= req.last_pass;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + pp_sh;
        b_r   <= b_r >> MUL_LEG;
        if (k_r == last_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// File: rtl/ar1ps_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to score width.
// Depends on ar1ps_pkg.
`default_nettype none
module ar1ps_div import ar1ps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done,
  output logic [SCORE_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]   dvd_r;
  logic [DSR_W-1:0]   dsr_r;
  logic [DSR_W:0]     rem_r;
  logic [SCORE_W-1:0] q_r;
  logic               ovf_r, busy_r, done_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [DSR_W:0] rem_sh;
  logic           ge;

  always_comb begin
    rem_sh = {rem_r[DSR_W-1:0], dvd_r[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= CNT_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
        q_r   <= {q_r[SCORE_W-2:0], ge};
        ovf_r <= ovf_r | q_r[SCORE_W-1];
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = ovf_r ? SCORE_MAX : q_r;

endmodule
`default_nettype wire

// File: rtl/ar1_penalty_score_unit.sv
// AR(1) penalty score unit: sequencer around one shared multiplier and a divider.
// Throughput: one sample at a time; ready only in idle. A plain sample holds ready low
// through S_DEV, S_RHO, S_SQ and S_UPD (S_DEV, S_UPD on the first of a series). A positive
// log-mode sample adds S_NORM (normalize one bit per cycle), S_LSQ (16 squaring passes) and
// S_LN2 (ln2 scaling). The last sample adds S_SIG, S_MS, the 110-step division and S_OUT.
// Reset (synchronous, rst_n low) loads the register defaults and clears the series state.
`default_nettype none
module ar1_penalty_score_unit import ar1ps_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ar1ps_in_if.sink    in_if,
  ar1ps_out_if.source out_if,
  ar1ps_cfg_if.sink   cfg_if
);

  localparam int F   = FRAC_BITS;
  localparam int KW  = $clog2(FRAC_BITS);
  localparam int L2W = FRAC_BITS + 6;
  localparam int RW  = DEV_W + 17;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LSQ, S_LN2, S_DEV, S_RHO, S_SQ, S_UPD,
    S_SIG, S_MS, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [RHO_W-1:0]    rho_r, rho_nxt;
  logic [SIGMA_W-1:0]  sigma_r, sigma_nxt;
  logic [SAMPLE_W-1:0] mean_r, mean_nxt;
  logic [MULT_W-1:0]   mult_r, mult_nxt;
  logic                log_mode_r, log_mode_nxt;

  // series state
  logic [DEV_W-1:0] prev_r, prev_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             derr_r, derr_nxt;

  // per-sample working registers
  logic [SAMPLE_W-1:0] x_r, x_nxt;
  logic                last_r, last_nxt;
  logic [31:0]         m_r, m_nxt;
  logic [4:0]          p_r, p_nxt;
  logic [F-1:0]        frac_r, frac_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [DEV_W-1:0]    dev_r, dev_nxt;
  logic [MUL_A_W-1:0]  a_r, a_nxt;
  logic [DSR_W-1:0]    d_r, d_nxt;
  logic                wait_r, wait_nxt;

  // staged and output result
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic               ovld_r, ovld_nxt;
  logic [SCORE_W-1:0] oscore_r, oscore_nxt;
  logic [ERR_W-1:0]   oerr_r, oerr_nxt;

  // shared units
  mul_req_t           mul_req;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd;
  logic [SCORE_W-1:0] div_q;

  // datapath temporaries
  logic [31:0]      t;
  logic [5:0]       pmf;
  logic [L2W-1:0]   l2, mag;
  logic [MUL_B_W-1:0] rnd;
  logic [31:0]      q;
  logic [DEV_W-1:0] prev_mag;
  logic [RHO_W-1:0] rho_mag;
  logic [RW-1:0]    rp, rps, devs, r, rabs, rr;
  logic [SUM_W:0]   sum_ext;
  logic [1:0]       cnt_inc;

  ar1ps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ar1ps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_if.ready       = (state_r == S_IDLE);
  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = ovld_r;
  assign out_if.score      = oscore_r;
  assign out_if.error_code = oerr_r;

  always_comb begin
    state_nxt    = state_r;
    rho_nxt      = rho_r;
    sigma_nxt    = sigma_r;
    mean_nxt     = mean_r;
    mult_nxt     = mult_r;
    log_mode_nxt = log_mode_r;
    prev_nxt     = prev_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    derr_nxt     = derr_r;
    x_nxt        = x_r;
    last_nxt     = last_r;
    m_nxt        = m_r;
    p_nxt        = p_r;
    frac_nxt     = frac_r;
    k_nxt        = k_r;
    dev_nxt      = dev_r;
    a_nxt        = a_r;
    d_nxt        = d_r;
    wait_nxt     = wait_r;
    score_nxt    = score_r;
    err_nxt      = err_r;
    ovld_nxt     = ovld_r & ~out_if.ready;
    oscore_nxt   = oscore_r;
    oerr_nxt     = oerr_r;
    mul_req      = '0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;

    t        = mul_prod[61:30];
    pmf      = 6'(p_r) - 6'(F);
    l2       = {pmf, frac_r};
    mag      = l2[L2W-1] ? (~l2 + 1'b1) : l2;
    rnd      = mul_prod[MUL_B_W-1:0] + MUL_B_W'(33'h0_8000_0000);
    q        = rnd[63:32];
    prev_mag = prev_r[DEV_W-1] ? (~prev_r + 1'b1) : prev_r;
    rho_mag  = rho_r[RHO_W-1] ? (~rho_r + 1'b1) : rho_r;
    rp       = RW'(mul_prod[DEV_W+RHO_W-1:0]);
    rps      = (prev_r[DEV_W-1] ^ rho_r[RHO_W-1]) ? (~rp + 1'b1) : rp;
    devs     = {{2{dev_r[DEV_W-1]}}, dev_r, 15'd0};
    r        = devs - rps;
    rabs     = r[RW-1] ? (~r + 1'b1) : r;
    rr       = rabs + RW'(16384);
    sum_ext  = {1'b0, sum_r} + (SUM_W+1)'(mul_prod[F+SUM_W-1:F]);
    cnt_inc  = (cnt_r == 2'd2) ? 2'd2 : cnt_r + 2'd1;
    div_dvd  = {mul_prod[MS_W-1:0], {(F-1){1'b0}}};

    // register writes land at any time; the host must write only while idle, which the block does not enforce
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_RHO:      rho_nxt      = cfg_if.data[RHO_W-1:0];
        CFG_SIGMA:    sigma_nxt    = cfg_if.data[SIGMA_W-1:0];
        CFG_MEAN:     mean_nxt     = cfg_if.data;
        CFG_MULT:     mult_nxt     = cfg_if.data[MULT_W-1:0];
        CFG_LOG_MODE: log_mode_nxt = cfg_if.data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          x_nxt    = in_if.sample;
          last_nxt = in_if.is_last;
          if (!log_mode_r) begin
            state_nxt = S_DEV;
          end else if (in_if.sample[SAMPLE_W-1] || in_if.sample == '0) begin
            // non-positive in log mode: log taken as zero, flag the series
            derr_nxt  = 1'b1;
            x_nxt     = '0;
            state_nxt = S_DEV;
          end else begin
            m_nxt     = {1'b0, in_if.sample[30:0]};
            p_nxt     = 5'd30;
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        // find the leading one, one position per cycle
        if (m_r[30]) begin
          k_nxt     = '0;
          frac_nxt  = '0;
          state_nxt = S_LSQ;
        end else begin
          m_nxt = m_r << 1;
          p_nxt = p_r - 5'd1;
        end
      end
      S_LSQ: begin
        // one log2 fraction bit per square of the Q1.30 mantissa
        mul_a = MUL_A_W'(m_r);
        mul_b = MUL_B_W'(m_r);
        mul_req.last_pass = MUL_K_W'(1);
        if (!wait_r) begin
          mul_req.start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (mul_done) begin
          wait_nxt = 1'b0;
          frac_nxt = {frac_r[F-2:0], t[31]};
          m_nxt    = t[31] ? (t >> 1) : t;
          k_nxt    = k_r + 1'b1;
          if (k_r == KW'(F - 1)) state_nxt = S_LN2;
        end
      end
      S_LN2: begin
        // scale log2 by ln2, round half away from zero
        mul_a = MUL_A_W'(LN2_Q32);
        mul_b = MUL_B_W'(mag);
        mul_req.last_pass = MUL_K_W'(1);
        if (!wait_r) begin
          mul_req.start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (mul_done) begin
          wait_nxt  = 1'b0;
          x_nxt     = l2[L2W-1] ? (~q + 1'b1) : q;
          state_nxt = S_DEV;
        end
      end
      S_DEV: begin
        dev_nxt   = {{2{x_r[SAMPLE_W-1]}}, x_r} - {{2{mean_r[SAMPLE_W-1]}}, mean_r};
        state_nxt = (cnt_r != 2'd0) ? S_RHO : S_UPD;
      end
      S_RHO: begin
        mul_a = MUL_A_W'(prev_mag);
        mul_b = MUL_B_W'(rho_mag);
        mul_req.last_pass = MUL_K_W'(0);
        if (!wait_r) begin
          mul_req.start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (mul_done) begin
          wait_nxt  = 1'b0;
          a_nxt     = rr[RW-1:15];
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        mul_a = a_r;
        mul_b = MUL_B_W'(a_r);
        mul_req.last_pass = MUL_K_W'(1);
        if (!wait_r) begin
          mul_req.start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (mul_done) begin
          wait_nxt  = 1'b0;
          sum_nxt   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        prev_nxt = dev_r;
        cnt_nxt  = cnt_inc;
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (cnt_r == 2'd0) begin
          score_nxt = '0;
          err_nxt   = ERR_FEW;
          state_nxt = S_OUT;
        end else if (derr_r) begin
          score_nxt = '0;
          err_nxt   = ERR_DOMAIN;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SIG;
        end
      end
      S_SIG: begin
        mul_a = MUL_A_W'(sigma_r);
        mul_b = MUL_B_W'(sigma_r);
        mul_req.last_pass = MUL_K_W'(1);
        if (!wait_r) begin
          mul_req.start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (mul_done) begin
          wait_nxt  = 1'b0;
          d_nxt     = mul_prod[DSR_W-1:0];
          state_nxt = S_MS;
        end
      end
      S_MS: begin
        mul_a = MUL_A_W'(mult_r);
        mul_b = MUL_B_W'(sum_r);
        mul_req.last_pass = MUL_K_W'(MUL_NPASS - 1);
        if (!wait_r) begin
          mul_req.start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (mul_done) begin
          wait_nxt = 1'b0;
          err_nxt  = ERR_OK;
          if (d_r == '0) begin
            // zero sigma: saturate unless the numerator is zero
            score_nxt = (mul_prod[MS_W-1:0] != '0) ? SCORE_MAX : '0;
            state_nxt = S_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          score_nxt = div_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free, then clear the series
        if (!ovld_r || out_if.ready) begin
          ovld_nxt   = 1'b1;
          oscore_nxt = score_r;
          oerr_nxt   = err_r;
          prev_nxt   = '0;
          cnt_nxt    = 2'd0;
          sum_nxt    = '0;
          derr_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rho_r      <= '0;
      sigma_r    <= SIGMA_W'(1 << F);
      mean_r     <= '0;
      mult_r     <= MULT_W'(1 << F);
      log_mode_r <= 1'b0;
      prev_r     <= '0;
      cnt_r      <= 2'd0;
      sum_r      <= '0;
      derr_r     <= 1'b0;
      wait_r     <= 1'b0;
      ovld_r     <= 1'b0;
      oscore_r   <= '0;
      oerr_r     <= ERR_OK;
    end else begin
      state_r    <= state_nxt;
      rho_r      <= rho_nxt;
      sigma_r    <= sigma_nxt;
      mean_r     <= mean_nxt;
      mult_r     <= mult_nxt;
      log_mode_r <= log_mode_nxt;
      prev_r     <= prev_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      derr_r     <= derr_nxt;
      wait_r     <= wait_nxt;
      ovld_r     <= ovld_nxt;
      oscore_r   <= oscore_nxt;
      oerr_r     <= oerr_nxt;
    end
  end

  // working payload, no reset
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    last_r  <= last_nxt;
    m_r     <= m_nxt;
    p_r     <= p_nxt;
    frac_r  <= frac_nxt;
    k_r     <= k_nxt;
    dev_r   <= dev_nxt;
    a_r     <= a_nxt;
    d_r     <= d_nxt;
    score_r <= score_nxt;
    err_r   <= err_nxt;
  end

endmodule
`default_nettype wire
